// ===== hw/rtl/tlru_pkg.sv =====
// Shared constants and elaboration-time helpers for the true-LRU permutation update.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlru_pkg;

    localparam int MAX_WAYS = 8;

    function automatic int tlru_fact(input int n);
        int r;
        r = 1;
        for (int i = 2; i <= n; i++)
        begin
            r = r * i;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tlru_dec_stage.sv =====
// One pipeline stage of the rank decoder: peels one factorial digit and places one way.
// Depends on tlru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlru_dec_stage #(
    parameter int WAYS = 4,
    parameter int POS  = 0
) (
    input  wire logic                                              clk,
    input  wire logic                                              rst_n,
    input  wire logic                                              en,
    input  wire logic                                              up_valid,
    input  wire logic                                              up_bad,
    input  wire logic [$clog2(tlru_pkg::tlru_fact(WAYS))-1:0]      up_rem,
    input  wire logic [$clog2(WAYS)-1:0]                           up_way,
    input  wire logic [WAYS-1:0]                                   up_taken,
    input  wire logic [WAYS-1:0][$clog2(WAYS)-1:0]                 up_perm,
    input  wire logic [WAYS-1:0][$clog2(WAYS)-1:0]                 up_dig,
    output logic                                                   dn_valid,
    output logic                                                   dn_bad,
    output logic [$clog2(tlru_pkg::tlru_fact(WAYS))-1:0]           dn_rem,
    output logic [$clog2(WAYS)-1:0]                                dn_way,
    output logic [WAYS-1:0]                                        dn_taken,
    output logic [WAYS-1:0][$clog2(WAYS)-1:0]                      dn_perm,
    output logic [WAYS-1:0][$clog2(WAYS)-1:0]                      dn_dig
);
    import tlru_pkg::*;

    localparam int SW     = $clog2(tlru_fact(WAYS));
    localparam int WW     = $clog2(WAYS);
    localparam int WEIGHT = tlru_fact(WAYS - 1 - POS);
    localparam int NDIG   = WAYS - 1 - POS;

    logic                         valid_reg;
    logic                         valid_next;
    logic                         bad_reg;
    logic [SW-1:0]                rem_reg;
    logic [SW-1:0]                rem_next;
    logic [WW-1:0]                way_reg;
    logic [WAYS-1:0]              taken_reg;
    logic [WAYS-1:0]              taken_next;
    logic [WAYS-1:0][WW-1:0]      perm_reg;
    logic [WAYS-1:0][WW-1:0]      perm_next;
    logic [WAYS-1:0][WW-1:0]      dig_reg;
    logic [WAYS-1:0][WW-1:0]      dig_next;
    logic [WW-1:0]                digit;
    logic [SW-1:0]                sub;
    logic [WW-1:0]                sel;
    logic [WW-1:0]                cnt;
    logic                         found;

    always_comb
    begin
        digit = '0;
        sub   = '0;
        for (int k = 1; k <= NDIG; k++)
        begin
            if (up_rem >= SW'(k * WEIGHT))
            begin
                digit = WW'(k);
                sub   = SW'(k * WEIGHT);
            end
        end
        rem_next = up_rem - sub;

        cnt   = '0;
        found = 1'b0;
        sel   = '0;
        for (int k = 0; k < WAYS; k++)
        begin
            if (!up_taken[k] && !found)
            begin
                if (cnt == digit)
                begin
                    sel   = WW'(k);
                    found = 1'b1;
                end
                else
                begin
                    cnt = cnt + 1'b1;
                end
            end
        end

        taken_next      = up_taken;
        taken_next[sel] = 1'b1;
        perm_next       = up_perm;
        perm_next[POS]  = sel;
        dig_next        = up_dig;
        dig_next[POS]   = digit;
        valid_next      = en ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad_reg   <= up_bad;
            rem_reg   <= rem_next;
            way_reg   <= up_way;
            taken_reg <= taken_next;
            perm_reg  <= perm_next;
            dig_reg   <= dig_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_bad   = bad_reg;
    assign dn_rem   = rem_reg;
    assign dn_way   = way_reg;
    assign dn_taken = taken_reg;
    assign dn_perm  = perm_reg;
    assign dn_dig   = dig_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/true_lru_permutation_update_core.sv =====
// Pipeline: WAYS decode stages, then one reorder stage, then one re-encode stage
// that is also the output register.
// Throughput: one transaction per cycle; the whole pipeline holds while a result
// waits under out_stall. Reset clears all valid bits; payload registers are not reset.
// Top level of the true-LRU permutation update; depends on tlru_pkg and tlru_dec_stage.
`timescale 1ns / 1ps
`default_nettype none

module true_lru_permutation_update_core #(
    parameter int WAYS = 4
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          in_valid,
    output logic                                               in_stall,
    input  wire logic [$clog2(tlru_pkg::tlru_fact(WAYS))-1:0]  state_code,
    input  wire logic [$clog2(WAYS)-1:0]                       used_way,
    output logic                                               out_valid,
    input  wire logic                                          out_stall,
    output logic [$clog2(tlru_pkg::tlru_fact(WAYS))-1:0]       next_state_code,
    output logic [$clog2(WAYS)-1:0]                            lru_way
);
    import tlru_pkg::*;

    localparam int SW     = $clog2(tlru_fact(WAYS));
    localparam int WW     = $clog2(WAYS);
    localparam int NPERMS = tlru_fact(WAYS);

    logic                             en;
    logic [WAYS:0]                    s_valid;
    logic [WAYS:0]                    s_bad;
    logic [WAYS:0][SW-1:0]            s_rem;
    logic [WAYS:0][WW-1:0]            s_way;
    logic [WAYS:0][WAYS-1:0]          s_taken;
    logic [WAYS:0][WAYS-1:0][WW-1:0]  s_perm;
    logic [WAYS:0][WAYS-1:0][WW-1:0]  s_dig;

    logic                             rv_reg;
    logic                             rv_next;
    logic                             rbad_reg;
    logic [WW-1:0]                    rlru_reg;
    logic [WAYS-1:0][WW-1:0]          rdig_reg;
    logic [WAYS-1:0][WW-1:0]          rdig_next;
    logic                             seen;
    logic [WAYS-1:0]                  ahead;

    logic                             ov_reg;
    logic                             ov_next;
    logic [SW-1:0]                    code_reg;
    logic [SW-1:0]                    code_next;
    logic [WW-1:0]                    lru_reg;
    logic [WW-1:0]                    lru_next;
    logic [SW-1:0]                    acc;

    assign en       = !(ov_reg && out_stall);
    assign in_stall = !en;

    assign s_valid[0] = in_valid;
    assign s_bad[0]   = ({1'b0, state_code} >= (SW + 1)'(NPERMS))
                        || ({1'b0, used_way} >= (WW + 1)'(WAYS));
    assign s_rem[0]   = state_code;
    assign s_way[0]   = used_way;
    assign s_taken[0] = '0;
    assign s_perm[0]  = '0;
    assign s_dig[0]   = '0;

    for (genvar p = 0; p < WAYS; p++)
    begin : g_dec
        tlru_dec_stage #(
            .WAYS (WAYS),
            .POS  (p)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (s_valid[p]),
            .up_bad   (s_bad[p]),
            .up_rem   (s_rem[p]),
            .up_way   (s_way[p]),
            .up_taken (s_taken[p]),
            .up_perm  (s_perm[p]),
            .up_dig   (s_dig[p]),
            .dn_valid (s_valid[p + 1]),
            .dn_bad   (s_bad[p + 1]),
            .dn_rem   (s_rem[p + 1]),
            .dn_way   (s_way[p + 1]),
            .dn_taken (s_taken[p + 1]),
            .dn_perm  (s_perm[p + 1]),
            .dn_dig   (s_dig[p + 1])
        );
    end

    // move the used way to the front: shifted digits lose one where the used way was smaller
    always_comb
    begin
        seen = 1'b0;
        for (int i = 0; i < WAYS; i++)
        begin
            seen     = seen || (s_perm[WAYS][i] == s_way[WAYS]);
            ahead[i] = !seen;
        end
        rdig_next    = s_dig[WAYS];
        rdig_next[0] = s_way[WAYS];
        for (int i = 0; i < WAYS - 1; i++)
        begin
            if (ahead[i])
            begin
                rdig_next[i + 1] = s_dig[WAYS][i]
                                   - WW'(s_way[WAYS] < s_perm[WAYS][i]);
            end
        end
        rv_next = en ? s_valid[WAYS] : rv_reg;
    end

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            acc = acc + SW'(rdig_reg[i]) * SW'(tlru_fact(WAYS - 1 - i));
        end
        code_next = rbad_reg ? '0 : acc;
        lru_next  = rbad_reg ? '0 : rlru_reg;
        ov_next   = en ? rv_reg : ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= rv_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rbad_reg <= s_bad[WAYS];
            rlru_reg <= s_perm[WAYS][WAYS - 1];
            rdig_reg <= rdig_next;
            code_reg <= code_next;
            lru_reg  <= lru_next;
        end
    end

    assign out_valid       = ov_reg;
    assign next_state_code = code_reg;
    assign lru_way         = lru_reg;

endmodule

`default_nettype wire
